### rtl/core/tlpw_pkg.sv
// shared types and constants for the traffic light with pedestrian walk core
package tlpw_pkg;

    localparam int unsigned DigitW = 4;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [1:0] {
        PH_RED    = 2'd0,
        PH_YELLOW = 2'd1,
        PH_GREEN  = 2'd2
    } t_phase;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RED_START    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_YELLOW_START = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_GREEN_START  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_WALK_START   = 2'd3;

    // clamp bounds and reset values of the start registers
    localparam logic [DigitW-1:0] RED_MIN    = 4'd1;
    localparam logic [DigitW-1:0] YELLOW_MIN = 4'd1;
    localparam logic [DigitW-1:0] GREEN_MIN  = 4'd2;
    localparam logic [DigitW-1:0] WALK_MIN   = 4'd0;
    localparam logic [DigitW-1:0] DIGIT_MAX  = 4'd9;

    localparam logic [DigitW-1:0] RED_RST    = 4'd9;
    localparam logic [DigitW-1:0] YELLOW_RST = 4'd5;
    localparam logic [DigitW-1:0] GREEN_RST  = 4'd9;
    localparam logic [DigitW-1:0] WALK_RST   = 4'd5;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    typedef struct packed {
        logic [DigitW-1:0] red_start;
        logic [DigitW-1:0] yellow_start;
        logic [DigitW-1:0] green_start;
        logic [DigitW-1:0] walk_start;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [DigitW-1:0] phase_count;
        logic              walk_active;
        logic [DigitW-1:0] walk_count;
        logic              lamp_r;
        logic              lamp_y;
        logic              lamp_g;
        logic              advert_on;
    } t_state;

    typedef struct packed {
        logic              display_valid;
        logic [DigitW-1:0] display_digit;
        logic              red_lamp;
        logic              yellow_lamp;
        logic              green_lamp;
        logic              advert_enable;
    } t_result;

endpackage

### rtl/core/tlpw_step.sv
// next-state and result logic for one word of the light controller
module tlpw_step (
    input  tlpw_pkg::t_state  i_state,
    input  tlpw_pkg::t_cfg    i_cfg,
    input  logic              i_op,
    input  logic              i_button_pressed,
    output tlpw_pkg::t_state  o_state,
    output tlpw_pkg::t_result o_result
);

    // count the phase down after a digit was shown, switch phase at its end
    function automatic tlpw_pkg::t_state phase_advance(tlpw_pkg::t_state s,
                                                       tlpw_pkg::t_cfg c);
        tlpw_pkg::t_state r;
        r = s;
        case (s.phase)
            tlpw_pkg::PH_RED: begin
                if (s.phase_count == '0) begin
                    r.phase       = tlpw_pkg::PH_YELLOW;
                    r.phase_count = c.yellow_start;
                end else begin
                    r.phase_count = s.phase_count - 4'd1;
                end
            end
            tlpw_pkg::PH_YELLOW: begin
                if (s.phase_count == '0) begin
                    r.phase       = tlpw_pkg::PH_GREEN;
                    r.phase_count = c.green_start;
                end else begin
                    r.phase_count = s.phase_count - 4'd1;
                end
            end
            default: begin
                if (s.phase_count <= 4'd1) begin
                    r.phase       = tlpw_pkg::PH_RED;
                    r.phase_count = c.red_start;
                end else begin
                    r.phase_count = s.phase_count - 4'd1;
                end
            end
        endcase
        return r;
    endfunction

    tlpw_pkg::t_state  s;
    logic [3:0]        digit;
    logic              shown;

    always_comb begin
        s     = i_state;
        digit = '0;
        shown = 1'b0;
        if (i_op == tlpw_pkg::OP_TICK) begin
            shown = 1'b1;
            if (i_state.walk_active) begin
                if (i_state.walk_count == '0) begin
                    // walk over: restore paused lamp, then run the phase tick
                    s.walk_active = 1'b0;
                    s.lamp_g      = 1'b0;
                    if (i_state.phase == tlpw_pkg::PH_RED) begin
                        s.advert_on = 1'b1;
                        s.lamp_r    = 1'b1;
                    end else begin
                        s.lamp_y = 1'b1;
                    end
                    digit = i_state.phase_count;
                    s     = phase_advance(s, i_cfg);
                end else begin
                    digit        = i_state.walk_count;
                    s.walk_count = i_state.walk_count - 4'd1;
                end
            end else begin
                case (i_state.phase)
                    tlpw_pkg::PH_RED: begin
                        if (i_state.phase_count == i_cfg.red_start) begin
                            s.advert_on = 1'b1;
                            s.lamp_g    = 1'b0;
                            s.lamp_r    = 1'b1;
                        end
                    end
                    tlpw_pkg::PH_YELLOW: begin
                        if (i_state.phase_count == i_cfg.yellow_start) begin
                            s.advert_on = 1'b0;
                            s.lamp_r    = 1'b0;
                            s.lamp_y    = 1'b1;
                        end
                    end
                    default: begin
                        if (i_state.phase_count == i_cfg.green_start) begin
                            s.lamp_y = 1'b0;
                            s.lamp_g = 1'b1;
                        end
                    end
                endcase
                digit = i_state.phase_count;
                s     = phase_advance(s, i_cfg);
            end
        end else begin
            if (i_button_pressed && !i_state.walk_active &&
                (i_state.phase == tlpw_pkg::PH_RED ||
                 i_state.phase == tlpw_pkg::PH_YELLOW)) begin
                s.walk_active = 1'b1;
                s.walk_count  = i_cfg.walk_start;
                if (i_state.phase == tlpw_pkg::PH_RED) begin
                    s.advert_on = 1'b0;
                    s.lamp_r    = 1'b0;
                end else begin
                    s.lamp_y = 1'b0;
                end
                s.lamp_g = 1'b1;
            end
        end
    end

    assign o_state                  = s;
    assign o_result.display_valid   = shown;
    assign o_result.display_digit   = digit;
    assign o_result.red_lamp        = s.lamp_r;
    assign o_result.yellow_lamp     = s.lamp_y;
    assign o_result.green_lamp      = s.lamp_g;
    assign o_result.advert_enable   = s.advert_on;

endmodule

### rtl/core/traffic_light_with_pedestrian_walk_core.sv
// top level of the traffic light controller with pedestrian walk request
//
//  channel   signals                                     direction
//  -------   -----------------------------------------   ---------
//  input     i_valid / o_ready, i_op, i_button_pressed   in
//  output    o_valid / i_ready, o_display_*, o_*_lamp,   out
//            o_advert_enable
//  config    i_cfg_we, i_cfg_addr, i_cfg_data            in
//
//  one word per cycle while o_ready is high: the state registers feed a single
//  combinational step, its result is registered in the output register, or in the skid while that is held
//  reset (synchronous, i_rst_n low) restores start values 9/5/9/5, phase red
//  at count 9, no walk, lamps and advert off, output buffer empty
//  a two-entry output buffer (output register plus skid) keeps o_ready high
//  while one result waits; o_ready drops only when both entries are full
module traffic_light_with_pedestrian_walk_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input word channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic       i_button_pressed,
    // result word channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_display_valid,
    output logic [3:0] o_display_digit,
    output logic       o_red_lamp,
    output logic       o_yellow_lamp,
    output logic       o_green_lamp,
    output logic       o_advert_enable,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [3:0] i_cfg_data
);

    // start registers, controller state, output buffer
    tlpw_pkg::t_cfg    r_cfg;
    tlpw_pkg::t_state  r_state;
    tlpw_pkg::t_state  n_state;
    tlpw_pkg::t_result n_result;
    tlpw_pkg::t_result r_out;
    tlpw_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;

    logic in_fire;
    logic out_free;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && o_ready;
    // output register can load this cycle: empty or being taken
    assign out_free = !r_out_valid || i_ready;

    // clamp a written value into the register's legal range
    function automatic logic [3:0] clamp(logic [3:0] v, logic [3:0] lo);
        logic [3:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > tlpw_pkg::DIGIT_MAX) begin
            r = tlpw_pkg::DIGIT_MAX;
        end
        return r;
    endfunction

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_start    <= tlpw_pkg::RED_RST;
            r_cfg.yellow_start <= tlpw_pkg::YELLOW_RST;
            r_cfg.green_start  <= tlpw_pkg::GREEN_RST;
            r_cfg.walk_start   <= tlpw_pkg::WALK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tlpw_pkg::CFG_RED_START:
                    r_cfg.red_start <= clamp(i_cfg_data, tlpw_pkg::RED_MIN);
                tlpw_pkg::CFG_YELLOW_START:
                    r_cfg.yellow_start <= clamp(i_cfg_data, tlpw_pkg::YELLOW_MIN);
                tlpw_pkg::CFG_GREEN_START:
                    r_cfg.green_start <= clamp(i_cfg_data, tlpw_pkg::GREEN_MIN);
                tlpw_pkg::CFG_WALK_START:
                    r_cfg.walk_start <= clamp(i_cfg_data, tlpw_pkg::WALK_MIN);
                default: begin
                end
            endcase
        end
    end

    // one step of the controller per accepted word
    tlpw_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_op             (i_op),
        .i_button_pressed (i_button_pressed),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= tlpw_pkg::PH_RED;
            r_state.phase_count <= tlpw_pkg::RED_RST;
            r_state.walk_active <= 1'b0;
            r_state.walk_count  <= '0;
            r_state.lamp_r      <= 1'b0;
            r_state.lamp_y      <= 1'b0;
            r_state.lamp_g      <= 1'b0;
            r_state.advert_on   <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // output buffer control: skid drains first, new word never bypasses it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output buffer payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_result;
            end
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_display_valid = r_out.display_valid;
    assign o_display_digit = r_out.display_digit;
    assign o_red_lamp      = r_out.red_lamp;
    assign o_yellow_lamp   = r_out.yellow_lamp;
    assign o_green_lamp    = r_out.green_lamp;
    assign o_advert_enable = r_out.advert_enable;

endmodule

### test/tlpw_checker.sv
// scoreboard for the traffic light core: predicts every result word and compares it
`timescale 1ns / 100ps

module tlpw_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_op,
    input  logic              i_button_pressed,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  tlpw_pkg::t_result i_word,
    output int                o_fail_count,
    output int                o_words_due
);

    tlpw_pkg::t_cfg              cfg;
    tlpw_pkg::t_phase            lit_phase;
    logic [tlpw_pkg::DigitW-1:0] phase_digit;
    logic                        walking;
    logic [tlpw_pkg::DigitW-1:0] walk_digit;
    logic                        lamp_r, lamp_y, lamp_g, advert;
    tlpw_pkg::t_result           lamp_words_due[$];
    int                          fails = 0;

    assign o_fail_count = fails;
    assign o_words_due  = lamp_words_due.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fails++;
    endtask

    function automatic logic [tlpw_pkg::DigitW-1:0] clamp_start(
        input logic [tlpw_pkg::DigitW-1:0] v,
        input logic [tlpw_pkg::DigitW-1:0] lo);
        if (v < lo) return lo;
        if (v > tlpw_pkg::DIGIT_MAX) return tlpw_pkg::DIGIT_MAX;
        return v;
    endfunction

    function automatic void count_phase_down();
        if (lit_phase == tlpw_pkg::PH_RED || lit_phase == tlpw_pkg::PH_YELLOW) begin
            if (phase_digit == 0) begin
                if (lit_phase == tlpw_pkg::PH_RED) begin
                    lit_phase   = tlpw_pkg::PH_YELLOW;
                    phase_digit = cfg.yellow_start;
                end else begin
                    lit_phase   = tlpw_pkg::PH_GREEN;
                    phase_digit = cfg.green_start;
                end
            end else begin
                phase_digit--;
            end
        end else if (phase_digit <= 1) begin
            lit_phase   = tlpw_pkg::PH_RED;
            phase_digit = cfg.red_start;
        end else begin
            phase_digit--;
        end
    endfunction

    function automatic tlpw_pkg::t_result predict_lights(input logic op, input logic btn);
        tlpw_pkg::t_result r;
        r = '0;
        if (op == tlpw_pkg::OP_TICK) begin
            r.display_valid = 1'b1;
            if (walking && walk_digit != 0) begin
                r.display_digit = walk_digit;
                walk_digit--;
            end else begin
                if (walking) begin
                    walking = 1'b0;
                    lamp_g  = 1'b0;
                    if (lit_phase == tlpw_pkg::PH_RED) begin
                        advert = 1'b1;
                        lamp_r = 1'b1;
                    end else begin
                        lamp_y = 1'b1;
                    end
                end else if (lit_phase == tlpw_pkg::PH_RED) begin
                    if (phase_digit == cfg.red_start) begin
                        advert = 1'b1;
                        lamp_g = 1'b0;
                        lamp_r = 1'b1;
                    end
                end else if (lit_phase == tlpw_pkg::PH_YELLOW) begin
                    if (phase_digit == cfg.yellow_start) begin
                        advert = 1'b0;
                        lamp_r = 1'b0;
                        lamp_y = 1'b1;
                    end
                end else if (phase_digit == cfg.green_start) begin
                    lamp_y = 1'b0;
                    lamp_g = 1'b1;
                end
                r.display_digit = phase_digit;
                count_phase_down();
            end
        end else if (btn && lit_phase != tlpw_pkg::PH_GREEN && !walking) begin
            walking    = 1'b1;
            walk_digit = cfg.walk_start;
            if (lit_phase == tlpw_pkg::PH_RED) begin
                advert = 1'b0;
                lamp_r = 1'b0;
            end else begin
                lamp_y = 1'b0;
            end
            lamp_g = 1'b1;
        end
        r.red_lamp      = lamp_r;
        r.yellow_lamp   = lamp_y;
        r.green_lamp    = lamp_g;
        r.advert_enable = advert;
        return r;
    endfunction

    always @(posedge i_clk) begin
        tlpw_pkg::t_result want;
        if (!i_rst_n) begin
            cfg         = '{red_start: tlpw_pkg::RED_RST, yellow_start: tlpw_pkg::YELLOW_RST,
                            green_start: tlpw_pkg::GREEN_RST,
                            walk_start: tlpw_pkg::WALK_RST};
            lit_phase   = tlpw_pkg::PH_RED;
            phase_digit = tlpw_pkg::RED_RST;
            walking     = 1'b0;
            walk_digit  = '0;
            {lamp_r, lamp_y, lamp_g, advert} = '0;
            lamp_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    tlpw_pkg::CFG_RED_START:
                        cfg.red_start = clamp_start(i_cfg_data, tlpw_pkg::RED_MIN);
                    tlpw_pkg::CFG_YELLOW_START:
                        cfg.yellow_start = clamp_start(i_cfg_data, tlpw_pkg::YELLOW_MIN);
                    tlpw_pkg::CFG_GREEN_START:
                        cfg.green_start = clamp_start(i_cfg_data, tlpw_pkg::GREEN_MIN);
                    tlpw_pkg::CFG_WALK_START:
                        cfg.walk_start = clamp_start(i_cfg_data, tlpw_pkg::WALK_MIN);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (lamp_words_due.size() == 0) begin
                    report("word with none due", 1, 0);
                end else begin
                    want = lamp_words_due.pop_front();
                    if (i_word.display_valid !== want.display_valid)
                        report("display_valid", i_word.display_valid, want.display_valid);
                    if (i_word.display_digit !== want.display_digit)
                        report("display_digit", i_word.display_digit, want.display_digit);
                    if (i_word.red_lamp !== want.red_lamp)
                        report("red_lamp", i_word.red_lamp, want.red_lamp);
                    if (i_word.yellow_lamp !== want.yellow_lamp)
                        report("yellow_lamp", i_word.yellow_lamp, want.yellow_lamp);
                    if (i_word.green_lamp !== want.green_lamp)
                        report("green_lamp", i_word.green_lamp, want.green_lamp);
                    if (i_word.advert_enable !== want.advert_enable)
                        report("advert_enable", i_word.advert_enable, want.advert_enable);
                end
            end
            if (i_in_valid && i_in_ready)
                lamp_words_due.push_back(predict_lights(i_op, i_button_pressed));
        end
    end

endmodule

### test/tb.sv
// testbench top: drives the traffic light core and gives the verdict
`timescale 1ns / 100ps

module tb;

    // generous bound on the length of the run
    localparam int CycleLimit = 300000;
    localparam int Latency    = 4;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              op;
    logic              button_pressed;
    logic              out_valid;
    logic              out_ready = 1'b0;
    wire tlpw_pkg::t_result word;
    logic              cfg_we;
    logic [1:0]        cfg_addr;
    logic [3:0]        cfg_data;
    int                fail_count;
    int                words_due;
    int                cycles = 0;
    int                stall_left = 0;
    int                stall_mode = 0;

    // register addresses in write order
    logic [1:0] reg_addr [4] = '{tlpw_pkg::CFG_RED_START, tlpw_pkg::CFG_YELLOW_START,
                                 tlpw_pkg::CFG_GREEN_START, tlpw_pkg::CFG_WALK_START};

    traffic_light_with_pedestrian_walk_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_op             (op),
        .i_button_pressed (button_pressed),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_display_valid  (word.display_valid),
        .o_display_digit  (word.display_digit),
        .o_red_lamp       (word.red_lamp),
        .o_yellow_lamp    (word.yellow_lamp),
        .o_green_lamp     (word.green_lamp),
        .o_advert_enable  (word.advert_enable),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_data       (cfg_data)
    );

    tlpw_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_op             (op),
        .i_button_pressed (button_pressed),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_word           (word),
        .o_fail_count     (fail_count),
        .o_words_due      (words_due)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hang or a lost word ends here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls on its own pattern: always ready, mostly ready,
    // mostly stalled, or one cycle in eight; the mode is redrawn at random
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_left % 8 == 0);
        endcase
    end

    // present one word and hold it until accepted
    task automatic send_word(input logic w_op, input logic w_btn);
        in_valid       <= 1'b1;
        op             <= w_op;
        button_pressed <= w_btn;
        do @(posedge clk); while (!in_ready);
    endtask

    // wait until every predicted word has come out, then let the pipe settle
    task automatic drain();
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (Latency) @(posedge clk);
    endtask

    // write all four start registers back to back, only while idle
    task automatic write_starts(input logic [3:0] red, input logic [3:0] yellow,
                                input logic [3:0] green, input logic [3:0] walk);
        logic [3:0] vals [4];
        vals = '{red, yellow, green, walk};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= reg_addr[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // directed words: T tick, t tick with the button bit set,
    // P pressed sample, p released sample; anything else is skipped
    task automatic send_script(input string s);
        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "T": send_word(tlpw_pkg::OP_TICK, 1'b0);
                "t": send_word(tlpw_pkg::OP_TICK, 1'b1);
                "P": send_word(tlpw_pkg::OP_BUTTON, 1'b1);
                "p": send_word(tlpw_pkg::OP_BUTTON, 1'b0);
                default: ;
            endcase
        end
        in_valid <= 1'b0;
    endtask

    // random traffic in bursts; ticks dominate so the phases keep turning,
    // presses are frequent enough that walks start in red and yellow alike
    task automatic send_random(input int count);
        int   sent;
        int   burst;
        int   gap;
        logic hold;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                if ($urandom_range(0, 99) < 65)
                    send_word(tlpw_pkg::OP_TICK, 1'($urandom_range(0, 1)));
                else
                    send_word(tlpw_pkg::OP_BUTTON, $urandom_range(0, 99) < 60);
                sent++;
            end
            gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            hold = ($urandom_range(0, 39) == 0);
            if (sent == count || gap > 0 || hold)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then hold off until the core has nothing in flight
            if (hold)
                drain();
        end
    endtask

    initial begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        op             <= tlpw_pkg::OP_TICK;
        button_pressed <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_addr       <= tlpw_pkg::CFG_RED_START;
        cfg_data       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset starts: press before the first tick, walk runs out and red resumes,
        // released button ignored, second walk, press during a walk ignored
        send_script("P tTtTtT p P P TtTTtT");
        drain();

        // all starts at their low clamp, walk of zero length
        write_starts(4'd0, 4'd0, 4'd0, 4'd0);
        send_script("TTTPTTPTTTPTPT");
        drain();

        // random phases: high clamp, low clamp, top digit, then random settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       write_starts(4'd15, 4'd15, 4'd15, 4'd15);
                1:       write_starts(4'd0, 4'd0, 4'd0, 4'd0);
                2:       write_starts(4'd9, 4'd9, 4'd9, 4'd9);
                default: write_starts(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            endcase
            send_random(200);
            drain();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
